/* design/irt_pkg.sv */
`default_nettype none
package irt_pkg;

  localparam int NUM_INDEX_REGS = 16;
  localparam int REG_IDX_W      = $clog2(NUM_INDEX_REGS);
  localparam int ADDR_W         = 15;
  localparam int REGV_W         = ADDR_W + 1;
  localparam int HALF_W         = 24;
  localparam int BOUND_W        = 16;

  localparam logic [REGV_W-1:0] REG_UNK  = 16'h8000;
  localparam logic [REGV_W-1:0] REG_ZERO = 16'h0000;

  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_REGION_END   = 2'd1;
  localparam logic [1:0] CFG_BASE_REG     = 2'd2;
  localparam logic [1:0] CFG_BASE_ADDR    = 2'd3;

  typedef enum logic [1:0] {
    K_START   = 2'd0,
    K_ANALYZE = 2'd1,
    K_LOAD    = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    C_ILL    = 4'd0,
    C_SHORT  = 4'd1,
    C_LSTORE = 4'd2,
    C_IMM    = 4'd3,
    C_REGS   = 4'd4,
    C_STOP   = 4'd5,
    C_JUMP   = 4'd6,
    C_BRANCH = 4'd7,
    C_CALL   = 4'd8,
    C_SHIFT  = 4'd9,
    C_IRET   = 4'd10,
    C_AMOD   = 4'd11,
    C_REGL   = 4'd12,
    C_XIMM   = 4'd13,
    C_XADDR  = 4'd14
  } cls_t;

  localparam cls_t SHORT_CLS [64] = '{
    C_SHORT, C_SHORT, C_IMM,   C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT,
    C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT,
    C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT, C_SHORT,
    C_IMM,   C_SHIFT, C_ILL,   C_IMM,   C_SHIFT, C_SHIFT, C_SHIFT, C_IMM,
    C_REGS,  C_REGS,  C_REGS,  C_REGS,  C_REGS,  C_REGS,  C_ILL,   C_ILL,
    C_XIMM,  C_XIMM,  C_XIMM,  C_XIMM,  C_XIMM,  C_XIMM,  C_XIMM,  C_XIMM,
    C_XADDR, C_XADDR, C_XIMM,  C_XIMM,  C_XADDR, C_XIMM,  C_XIMM,  C_XADDR,
    C_XADDR, C_XADDR, C_XADDR, C_XADDR, C_XIMM,  C_XADDR, C_XIMM,  C_XIMM
  };

  localparam cls_t LONG_CLS [16] = '{
    C_ILL,    C_ILL,    C_AMOD,   C_AMOD,   C_REGL,   C_REGL,   C_BRANCH, C_BRANCH,
    C_JUMP,   C_CALL,   C_IRET,   C_STOP,   C_BRANCH, C_BRANCH, C_BRANCH, C_BRANCH
  };

  typedef struct packed {
    logic [1:0]        kind;
    logic [HALF_W-1:0] half_word;
    logic [ADDR_W-1:0] word_addr;
    logic              is_right;
    logic [REG_IDX_W-1:0] reg_index;
    logic [ADDR_W-1:0] reg_value;
    logic              reg_known;
  } item_t;

  typedef struct packed {
    logic [3:0]        insn_class;
    logic              falls_through;
    logic              target_valid;
    logic [ADDR_W-1:0] target_addr;
    logic              return_valid;
    logic [ADDR_W-1:0] return_addr;
    logic              data_valid;
    logic [ADDR_W-1:0] data_addr;
    logic              no_right;
  } res_t;

  typedef struct packed {
    logic [BOUND_W-1:0]   region_start;
    logic [BOUND_W-1:0]   region_end;
    logic [REG_IDX_W-1:0] base_reg;
    logic [ADDR_W-1:0]    base_addr;
  } cfg_t;

  typedef struct packed {
    logic                 clr;
    logic                 we;
    logic [REG_IDX_W-1:0] widx;
    logic [REGV_W-1:0]    wval;
    logic                 am_we;
    logic [REGV_W-1:0]    am_val;
  } upd_t;

endpackage
`default_nettype wire

/* design/irt_if.sv */
`default_nettype none
interface irt_in_if
  import irt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [HALF_W-1:0]    half_word;
  logic [ADDR_W-1:0]    word_addr;
  logic                 is_right;
  logic [REG_IDX_W-1:0] reg_index;
  logic [ADDR_W-1:0]    reg_value;
  logic                 reg_known;

  modport source (output valid, kind, half_word, word_addr, is_right, reg_index,
                  reg_value, reg_known, input ready);
  modport sink   (input valid, kind, half_word, word_addr, is_right, reg_index,
                  reg_value, reg_known, output ready);
endinterface

interface irt_out_if
  import irt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [3:0]        insn_class;
  logic              falls_through;
  logic              target_valid;
  logic [ADDR_W-1:0] target_addr;
  logic              return_valid;
  logic [ADDR_W-1:0] return_addr;
  logic              data_valid;
  logic [ADDR_W-1:0] data_addr;
  logic              no_right;

  modport source (output valid, insn_class, falls_through, target_valid, target_addr,
                  return_valid, return_addr, data_valid, data_addr, no_right,
                  input ready);
  modport sink   (input valid, insn_class, falls_through, target_valid, target_addr,
                  return_valid, return_addr, data_valid, data_addr, no_right,
                  output ready);
endinterface
`default_nettype wire

/* design/irt_regfile.sv */
`default_nettype none
module irt_regfile
  import irt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire upd_t                 upd,
  input  wire logic [REG_IDX_W-1:0] rd0_addr,
  input  wire logic [REG_IDX_W-1:0] rd1_addr,
  output logic      [REGV_W-1:0]    rd0_data,
  output logic      [REGV_W-1:0]    rd1_data,
  output logic      [REGV_W-1:0]    am
);

  logic [REGV_W-1:0] regs_r   [NUM_INDEX_REGS];
  logic [REGV_W-1:0] regs_nxt [NUM_INDEX_REGS];
  logic [REGV_W-1:0] am_r;
  logic [REGV_W-1:0] am_nxt;

  always_comb begin
    for (int i = 0; i < NUM_INDEX_REGS; i++) begin
      regs_nxt[i] = regs_r[i];
      if (en && upd.clr) begin
        regs_nxt[i] = (i == 0) ? REG_ZERO : REG_UNK;
      end
      if (en && upd.we && (i != 0) && (upd.widx == REG_IDX_W'(i))) begin
        regs_nxt[i] = upd.wval;
      end
    end
    am_nxt = (en && upd.am_we) ? upd.am_val : am_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INDEX_REGS; i++) begin
        regs_r[i] <= (i == 0) ? REG_ZERO : REG_UNK;
      end
      am_r <= REG_ZERO;
    end else begin
      for (int i = 0; i < NUM_INDEX_REGS; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
      am_r <= am_nxt;
    end
  end

  assign rd0_data = regs_r[rd0_addr];
  assign rd1_data = regs_r[rd1_addr];
  assign am       = am_r;

endmodule
`default_nettype wire

/* design/irt_analyze.sv */
`default_nettype none
module irt_analyze
  import irt_pkg::*;
(
  input  wire item_t                 item,
  input  wire cfg_t                  cfg,
  input  wire logic [REGV_W-1:0]     rval,
  input  wire logic [REGV_W-1:0]     rdat_a,
  input  wire logic [REGV_W-1:0]     am,
  output logic      [REG_IDX_W-1:0]  rd_reg,
  output logic      [REG_IDX_W-1:0]  rd_a,
  output res_t                       res,
  output upd_t                       upd
);

  localparam logic [5:0] SUB_AMOD_SET = 6'h12;
  localparam logic [5:0] SUB_REG_LOAD = 6'h14;
  localparam logic [5:0] SUB_BR_ABS   = 6'h1c;
  localparam logic [5:0] SUB_REG_KILL0 = 6'h20;
  localparam logic [5:0] SUB_REG_KILL1 = 6'h21;
  localparam logic [5:0] SUB_REG_COPY = 6'h24;
  localparam logic [5:0] SUB_REG_ADD  = 6'h25;
  localparam logic [ADDR_W-1:0] EXT_HI = 15'o70000;

  function automatic logic in_region(input logic [ADDR_W-1:0] a, input cfg_t c);
    logic [BOUND_W-1:0] w;
    w = {1'b0, a};
    return (w >= c.region_start) && (w < c.region_end);
  endfunction

  logic [HALF_W-1:0] op;
  logic              is_long;
  logic [5:0]        sub;
  cls_t              cls;
  logic              am_unk;
  logic              rv_unk;
  logic [ADDR_W-1:0] arg1;
  logic [ADDR_W-1:0] arg2;
  logic [ADDR_W-1:0] sum2;
  logic [ADDR_W-1:0] sum1;
  logic [ADDR_W-1:0] sum_a;
  logic [4:0]        kill5;
  logic [4:0]        a5;
  logic [ADDR_W-1:0] ret;

  always_comb begin
    op      = item.half_word;
    is_long = op[19];
    sub     = is_long ? {1'b0, op[19:15]} : op[17:12];
    cls     = is_long ? LONG_CLS[op[18:15]] : SHORT_CLS[op[17:12]];
    am_unk  = am[ADDR_W];
    rv_unk  = rval[ADDR_W];
    arg1    = ADDR_W'({3'b000, op[11:0]}) + (op[18] ? EXT_HI : '0) + am[ADDR_W-1:0];
    arg2    = op[ADDR_W-1:0] + am[ADDR_W-1:0];
    sum2    = arg2 + rval[ADDR_W-1:0];
    sum1    = arg1 + rval[ADDR_W-1:0];
    sum_a   = rdat_a[ADDR_W-1:0] + rval[ADDR_W-1:0];
    kill5   = arg1[4:0] + rval[4:0];
    a5      = arg1[4:0];
    ret     = item.word_addr + ADDR_W'(1);
    rd_reg  = op[23:20];
    rd_a    = a5[REG_IDX_W-1:0];

    res = '0;
    upd = '0;

    unique case (item.kind)
      K_START: begin
        upd.clr    = 1'b1;
        upd.am_we  = 1'b1;
        upd.am_val = REG_ZERO;
        if (cfg.base_reg != '0) begin
          upd.we   = 1'b1;
          upd.widx = cfg.base_reg;
          upd.wval = {1'b0, cfg.base_addr};
        end
      end
      K_LOAD: begin
        if (item.reg_index != '0) begin
          upd.we   = 1'b1;
          upd.widx = item.reg_index;
          upd.wval = item.reg_known ? {1'b0, item.reg_value} : REG_UNK;
        end
      end
      K_ANALYZE: begin
        res.insn_class = cls;
        upd.am_we      = 1'b1;
        upd.am_val     = REG_ZERO;
        unique case (cls)
          C_CALL: begin
            res.no_right = !item.is_right;
            if (!am_unk && in_region(arg2, cfg)) begin
              res.target_valid = 1'b1;
              res.target_addr  = arg2;
            end
            res.return_valid = 1'b1;
            res.return_addr  = ret;
            if (rd_reg != '0) begin
              upd.we   = 1'b1;
              upd.widx = rd_reg;
              upd.wval = {1'b0, ret};
            end
          end
          C_JUMP: begin
            res.no_right = !item.is_right;
            if (!am_unk && !rv_unk && in_region(sum2, cfg)) begin
              res.target_valid = 1'b1;
              res.target_addr  = sum2;
            end
          end
          C_BRANCH: begin
            res.falls_through = 1'b1;
            if (!am_unk) begin
              if (sub >= SUB_BR_ABS) begin
                if (in_region(arg2, cfg)) begin
                  res.target_valid = 1'b1;
                  res.target_addr  = arg2;
                end
              end else if (!rv_unk && in_region(sum2, cfg)) begin
                res.target_valid = 1'b1;
                res.target_addr  = sum2;
              end
            end
          end
          C_ILL, C_IRET: begin
          end
          C_REGS: begin
            res.falls_through = 1'b1;
            if (!am_unk) begin
              if (sub == SUB_REG_KILL0 || sub == SUB_REG_KILL1) begin
                if (!rv_unk && kill5 != '0 && !kill5[4]) begin
                  upd.we   = 1'b1;
                  upd.widx = kill5[REG_IDX_W-1:0];
                  upd.wval = REG_UNK;
                end
              end else if (sub == SUB_REG_COPY) begin
                if (a5 != '0 && !a5[4]) begin
                  upd.we   = 1'b1;
                  upd.widx = a5[REG_IDX_W-1:0];
                  upd.wval = rval;
                end
              end else if (sub == SUB_REG_ADD) begin
                if (a5 != '0 && !a5[4] && !rdat_a[ADDR_W]) begin
                  upd.we   = 1'b1;
                  upd.widx = a5[REG_IDX_W-1:0];
                  upd.wval = rv_unk ? REG_UNK : {1'b0, sum_a};
                end
              end
            end
          end
          C_REGL: begin
            res.falls_through = 1'b1;
            if (rd_reg != '0) begin
              if (sub == SUB_REG_LOAD) begin
                upd.we   = 1'b1;
                upd.widx = rd_reg;
                upd.wval = am_unk ? REG_UNK : {1'b0, arg2};
              end else if (!rv_unk) begin
                upd.we   = 1'b1;
                upd.widx = rd_reg;
                upd.wval = am_unk ? REG_UNK : {1'b0, sum2};
              end
            end
          end
          C_AMOD: begin
            res.falls_through = 1'b1;
            upd.am_val        = REG_UNK;
            if (sub == SUB_AMOD_SET) begin
              if (!rv_unk && !am_unk) begin
                upd.am_val = {1'b0, sum2};
              end
            end else if (!rv_unk && !am_unk) begin
              res.data_valid = 1'b1;
              res.data_addr  = sum2;
            end
          end
          C_SHORT: begin
            res.falls_through = 1'b1;
            if (!rv_unk && !am_unk) begin
              res.data_valid = 1'b1;
              res.data_addr  = sum1;
            end
          end
          C_XIMM, C_XADDR: begin
            if (cls == C_XADDR && !rv_unk && !am_unk) begin
              res.data_valid = 1'b1;
              res.data_addr  = sum1;
            end
            upd.we            = 1'b1;
            upd.widx          = REG_IDX_W'(14);
            upd.wval          = REG_UNK;
            res.no_right      = !item.is_right;
            res.falls_through = 1'b1;
          end
          default: begin
            res.falls_through = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/index_register_tracking_step_unit.sv */
// Index register tracking for 24-bit instruction halves. One beat enters per clock while the
// result side does not stall: an input register takes the beat, decode, operand address adds
// and register file update follow, and the result lands in an output register, so a result
// reaches the output through the input register and then the output register. The rate of
// one beat per cycle is set by the read-modify-write of the 16-entry index register file and
// the address modifier, which each beat may change for the next. The input register doubles
// as a skid stage, so a new beat is taken while a finished result waits. Start beats clear the
// tracking and apply the configured base register; load beats restore one register. Write
// configuration only while no beat is in flight.
`default_nettype none
module index_register_tracking_step_unit
  import irt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  irt_in_if.sink                  in_ch,
  irt_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [BOUND_W-1:0] cfg_wdata
);

  item_t                item_r;
  logic                 in_v_r;
  logic                 in_v_nxt;
  res_t                 res_r;
  logic                 out_v_r;
  logic                 out_v_nxt;
  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 advance;
  logic                 in_take;
  res_t                 res;
  upd_t                 upd;
  logic [REG_IDX_W-1:0] rd_reg;
  logic [REG_IDX_W-1:0] rd_a;
  logic [REGV_W-1:0]    rval;
  logic [REGV_W-1:0]    rdat_a;
  logic [REGV_W-1:0]    am;

  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);
    out_v_nxt = advance ? 1'b1 : ((out_v_r && out_ch.ready) ? 1'b0 : out_v_r);
    cfg_nxt   = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_START: cfg_nxt.region_start = cfg_wdata;
        CFG_REGION_END:   cfg_nxt.region_end   = cfg_wdata;
        CFG_BASE_REG:     cfg_nxt.base_reg     = cfg_wdata[REG_IDX_W-1:0];
        CFG_BASE_ADDR:    cfg_nxt.base_addr    = cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r             <= 1'b0;
      out_v_r            <= 1'b0;
      cfg_r.region_start <= '0;
      cfg_r.region_end   <= BOUND_W'(32768);
      cfg_r.base_reg     <= '0;
      cfg_r.base_addr    <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      cfg_r   <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind      <= in_ch.kind;
      item_r.half_word <= in_ch.half_word;
      item_r.word_addr <= in_ch.word_addr;
      item_r.is_right  <= in_ch.is_right;
      item_r.reg_index <= in_ch.reg_index;
      item_r.reg_value <= in_ch.reg_value;
      item_r.reg_known <= in_ch.reg_known;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  irt_analyze u_analyze (
    .item   (item_r),
    .cfg    (cfg_r),
    .rval   (rval),
    .rdat_a (rdat_a),
    .am     (am),
    .rd_reg (rd_reg),
    .rd_a   (rd_a),
    .res    (res),
    .upd    (upd)
  );

  irt_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .upd      (upd),
    .rd0_addr (rd_reg),
    .rd1_addr (rd_a),
    .rd0_data (rval),
    .rd1_data (rdat_a),
    .am       (am)
  );

  assign out_ch.valid         = out_v_r;
  assign out_ch.insn_class    = res_r.insn_class;
  assign out_ch.falls_through = res_r.falls_through;
  assign out_ch.target_valid  = res_r.target_valid;
  assign out_ch.target_addr   = res_r.target_addr;
  assign out_ch.return_valid  = res_r.return_valid;
  assign out_ch.return_addr   = res_r.return_addr;
  assign out_ch.data_valid    = res_r.data_valid;
  assign out_ch.data_addr     = res_r.data_addr;
  assign out_ch.no_right      = res_r.no_right;

endmodule
`default_nettype wire

/* design/irt_checker.sv */
`default_nettype none
module irt_port_checks
  import irt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [3:0]        insn_class,
  input wire logic              target_valid,
  input wire logic [ADDR_W-1:0] target_addr,
  input wire logic              return_valid,
  input wire logic              data_valid,
  input wire logic [ADDR_W-1:0] data_addr
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_ret_call: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && return_valid |-> insn_class == C_CALL)
    else $error("return address on a non-call beat");

  a_tgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !target_valid |-> target_addr == '0)
    else $error("target address set without target valid");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !data_valid |-> data_addr == '0)
    else $error("data address set without data valid");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind index_register_tracking_step_unit irt_port_checks u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .insn_class   (out_ch.insn_class),
  .target_valid (out_ch.target_valid),
  .target_addr  (out_ch.target_addr),
  .return_valid (out_ch.return_valid),
  .data_valid   (out_ch.data_valid),
  .data_addr    (out_ch.data_addr)
);
`default_nettype wire
